>>> rtl/swpi_pkg.sv
// swpi_pkg: shared types and codes for the stack with positional insert.
// Item structs, request/status codes and the back-end state encoding.
// No dependencies.
package swpi_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    // request kinds, as carried in the mode field
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_REDUCE = 2'd3
    } mode_t;

    // insert positions; the unused code maps to top
    typedef enum logic [1:0] {
        PL_TOP = 2'd0,
        PL_MID = 2'd1,
        PL_BOT = 2'd2
    } place_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [WORD_W-1:0] value;
        logic [1:0]               place;
        logic                     use_product;
        logic                     insert_result;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               status;
    } rsp_t;

    // classified request, front to back
    typedef struct packed {
        mode_t             op;
        logic [WORD_W-1:0] value;
        place_t            place;
        logic              use_product;
        logic              insert_result;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_POP_RD,
        S_POP_DONE,
        S_RED_RD,
        S_RED_ACC,
        S_RED_END,
        S_EMIT
    } state_t;

endpackage

>>> rtl/swpi_front.sv
// swpi_front: accepts request items, classifies them into commands and
// holds them in a two-entry queue for the back end. Uses swpi_pkg.
module swpi_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swpi_pkg::req_t    req,
    output logic              full,
    output logic              cmd_valid,
    output swpi_pkg::cmd_t    cmd,
    input  logic              cmd_pop
);

    swpi_pkg::cmd_t q_reg [2];
    logic [1:0]     fill_reg, fill_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_en, rd_en;
    swpi_pkg::cmd_t cls;

    // classify: decode mode, fold the unused place code onto top
    always_comb
    begin
        cls.value         = req.value;
        cls.use_product   = req.use_product;
        cls.insert_result = req.insert_result;
        case (req.mode)
            swpi_pkg::MODE_PUSH:  cls.op = swpi_pkg::MODE_PUSH;
            swpi_pkg::MODE_POP:   cls.op = swpi_pkg::MODE_POP;
            swpi_pkg::MODE_CLEAR: cls.op = swpi_pkg::MODE_CLEAR;
            default:              cls.op = swpi_pkg::MODE_REDUCE;
        endcase
        case (req.place)
            swpi_pkg::PL_MID: cls.place = swpi_pkg::PL_MID;
            swpi_pkg::PL_BOT: cls.place = swpi_pkg::PL_BOT;
            default:          cls.place = swpi_pkg::PL_TOP;
        endcase
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/swpi_out_queue.sv
// swpi_out_queue: two-entry result queue between the back end and the
// result ports. Uses swpi_pkg.
module swpi_out_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  swpi_pkg::rsp_t res,
    output logic           res_full,
    output logic           empty,
    output swpi_pkg::rsp_t rsp,
    input  logic           pop
);

    swpi_pkg::rsp_t q_reg [2];
    logic [1:0]     fill_reg, fill_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_en, rd_en;

    assign res_full = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign rsp      = q_reg[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

>>> rtl/swpi_back.sv
// swpi_back: executes commands on the stack memory (one write port, one
// registered read port) and forms one result per command. Uses swpi_pkg.
module swpi_back
#(
    parameter int DEPTH = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  swpi_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_push,
    output swpi_pkg::rsp_t res,
    input  logic           res_full
);

    localparam int CW       = $clog2(DEPTH + 1);
    localparam int AW       = $clog2(DEPTH);
    localparam int OUT_CW   = swpi_pkg::COUNT_W;
    localparam int WW       = swpi_pkg::WORD_W;

    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] rd_data_reg;

    swpi_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [WW-1:0]     word_reg, word_next;
    logic [WW-1:0]     acc_reg, acc_next;
    logic [WW-1:0]     data_reg, data_next;
    swpi_pkg::status_t status_reg, status_next;
    swpi_pkg::place_t  place_reg, place_next;
    logic              use_product_reg, use_product_next;
    logic              insert_reg, insert_next;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WW-1:0]     mem_wdata;

    logic [CW-1:0]     ptr_m1, ptr_p1, cnt_m1, ins_pos;
    logic              stack_full;
    logic [WW-1:0]     prod_lo, sum_lo;

    assign ptr_m1     = CW'(ptr_reg - 1'b1);
    assign ptr_p1     = CW'(ptr_reg + 1'b1);
    assign cnt_m1     = CW'(cnt_reg - 1'b1);
    assign stack_full = (cnt_reg == CW'(DEPTH));
    assign prod_lo    = WW'(acc_reg * rd_data_reg);
    assign sum_lo     = WW'(acc_reg + rd_data_reg);

    // middle insert lands floor(n/2) below the top
    always_comb
    begin
        case (place_reg)
            swpi_pkg::PL_MID: ins_pos = CW'(cnt_reg - (cnt_reg >> 1));
            swpi_pkg::PL_BOT: ins_pos = '0;
            default:          ins_pos = cnt_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swpi_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        swpi_pkg::MODE_PUSH:  state_next = swpi_pkg::S_INS;
                        swpi_pkg::MODE_POP:
                            state_next = (cnt_reg == '0) ? swpi_pkg::S_EMIT
                                                         : swpi_pkg::S_POP_RD;
                        swpi_pkg::MODE_CLEAR: state_next = swpi_pkg::S_EMIT;
                        default:
                            state_next = (cnt_reg == '0) ? swpi_pkg::S_RED_END
                                                         : swpi_pkg::S_RED_RD;
                    endcase
                end
            end
            swpi_pkg::S_INS:
            begin
                if (stack_full)
                begin
                    state_next = swpi_pkg::S_EMIT;
                end
                else if (ins_pos == cnt_reg)
                begin
                    state_next = swpi_pkg::S_PLACE;
                end
                else
                begin
                    state_next = swpi_pkg::S_SHIFT_RD;
                end
            end
            swpi_pkg::S_SHIFT_RD: state_next = swpi_pkg::S_SHIFT_WR;
            swpi_pkg::S_SHIFT_WR:
                state_next = (ptr_m1 == pos_reg) ? swpi_pkg::S_PLACE
                                                 : swpi_pkg::S_SHIFT_RD;
            swpi_pkg::S_PLACE:    state_next = swpi_pkg::S_EMIT;
            swpi_pkg::S_POP_RD:   state_next = swpi_pkg::S_POP_DONE;
            swpi_pkg::S_POP_DONE: state_next = swpi_pkg::S_EMIT;
            swpi_pkg::S_RED_RD:   state_next = swpi_pkg::S_RED_ACC;
            swpi_pkg::S_RED_ACC:
                state_next = (ptr_p1 == cnt_reg) ? swpi_pkg::S_RED_END
                                                 : swpi_pkg::S_RED_RD;
            swpi_pkg::S_RED_END:
                state_next = insert_reg ? swpi_pkg::S_INS : swpi_pkg::S_EMIT;
            swpi_pkg::S_EMIT:
                state_next = res_full ? swpi_pkg::S_EMIT : swpi_pkg::S_IDLE;
            default:              state_next = swpi_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd_pop          = 1'b0;
        res_push         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = ptr_reg[AW-1:0];
        mem_wdata        = rd_data_reg;
        mem_raddr        = ptr_m1[AW-1:0];
        cnt_next         = cnt_reg;
        ptr_next         = ptr_reg;
        pos_next         = pos_reg;
        word_next        = word_reg;
        acc_next         = acc_reg;
        data_next        = data_reg;
        status_next      = status_reg;
        place_next       = place_reg;
        use_product_next = use_product_reg;
        insert_next      = insert_reg;
        case (state_reg)
            swpi_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop          = 1'b1;
                    word_next        = cmd.value;
                    place_next       = cmd.place;
                    use_product_next = cmd.use_product;
                    insert_next      = cmd.insert_result;
                    data_next        = '0;
                    status_next      = swpi_pkg::ST_OK;
                    ptr_next         = '0;
                    acc_next         = cmd.use_product ? WW'(1) : '0;
                    case (cmd.op)
                        swpi_pkg::MODE_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = swpi_pkg::ST_EMPTY;
                            end
                        end
                        swpi_pkg::MODE_CLEAR: cnt_next = '0;
                        default:              cnt_next = cnt_reg;
                    endcase
                end
            end
            swpi_pkg::S_INS:
            begin
                if (stack_full)
                begin
                    status_next = swpi_pkg::ST_FULL;
                end
                else
                begin
                    pos_next = ins_pos;
                    ptr_next = cnt_reg;
                end
            end
            swpi_pkg::S_SHIFT_RD:
            begin
                mem_raddr = ptr_m1[AW-1:0];
            end
            swpi_pkg::S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_m1;
            end
            swpi_pkg::S_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = word_reg;
                cnt_next  = CW'(cnt_reg + 1'b1);
            end
            swpi_pkg::S_POP_RD:
            begin
                mem_raddr = cnt_m1[AW-1:0];
            end
            swpi_pkg::S_POP_DONE:
            begin
                data_next = rd_data_reg;
                cnt_next  = cnt_m1;
            end
            swpi_pkg::S_RED_RD:
            begin
                mem_raddr = ptr_reg[AW-1:0];
            end
            swpi_pkg::S_RED_ACC:
            begin
                acc_next = use_product_reg ? prod_lo : sum_lo;
                ptr_next = ptr_p1;
            end
            swpi_pkg::S_RED_END:
            begin
                data_next = acc_reg;
                word_next = acc_reg;
            end
            swpi_pkg::S_EMIT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // count field is the low bits of the entry count
    always_comb
    begin
        res.data   = data_reg;
        res.count  = OUT_CW'(cnt_reg);
        res.status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swpi_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        pos_reg         <= pos_next;
        word_reg        <= word_next;
        acc_reg         <= acc_next;
        data_reg        <= data_next;
        status_reg      <= status_next;
        place_reg       <= place_next;
        use_product_reg <= use_product_next;
        insert_reg      <= insert_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

>>> rtl/stack_with_positional_insert.sv
// stack_with_positional_insert: top level of the bounded LIFO stack with
// positional insert and sum/product reduce. Uses swpi_pkg, swpi_front,
// swpi_back and swpi_out_queue.
//
//   channel   direction  handshake               payload
//   request   in         push / full             req (swpi_pkg::req_t)
//   result    out        empty / pop             rsp (swpi_pkg::rsp_t)
//
// Each item is a walk by the back end over the stack memory, one read
// or one write per cycle:
//   clear, pop on empty: straight to the result; pop: read the top, then
//   drop the count; push on a full stack: status full; push: a read and a
//   write per entry moved down (none for a top push), then the item write;
//   reduce: a read and an accumulate per entry, then an insert as a push.
//   The result state repeats while the result queue is full.
// Reset (rst_n low, async) empties the stack and both queues; stack words
// hold no reset value and only entries below the count are ever read.
// Two request items queue ahead of the back end and two results queue
// behind it, so either side may stall without holding up the other.
module stack_with_positional_insert
#(
    parameter int DEPTH = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  swpi_pkg::req_t req,
    output logic           empty,
    input  logic           pop,
    output swpi_pkg::rsp_t rsp
);

    // front to back: classified command
    logic           cmd_valid;
    logic           cmd_pop;
    swpi_pkg::cmd_t cmd;

    // back to result queue
    logic           res_push;
    logic           res_full;
    swpi_pkg::rsp_t res;

    // front: classify requests, two-deep command queue
    swpi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: sequencer over the stack memory, one command at a time
    swpi_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res       (res),
        .res_full  (res_full)
    );

    // results wait here until popped
    swpi_out_queue u_out_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .rsp      (rsp),
        .pop      (pop)
    );

endmodule

>>> rtl/swpi_checker.sv
// swpi_checker: port-level assertions for stack_with_positional_insert,
// bound to the top level below. Uses swpi_pkg.
module swpi_checker
#(
    parameter int DEPTH = 64
)
(
    input logic           clk,
    input logic           rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input swpi_pkg::rsp_t rsp
);

    localparam int CNT_W = swpi_pkg::COUNT_W;

    // reset leaves both queues empty
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not empty in reset");

    // pop on empty stack reports a zero count and zero data
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == swpi_pkg::ST_EMPTY) |->
            (rsp.count == '0 && rsp.data == '0))
        else $error("empty-pop result carries data or count");

    // a dropped insert only happens on a full stack
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status == swpi_pkg::ST_FULL) |->
            (rsp.count == CNT_W'(DEPTH)))
        else $error("insert dropped below full");

    // a waiting result holds until popped
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("waiting result changed");

endmodule

bind stack_with_positional_insert swpi_checker
#(
    .DEPTH (DEPTH)
)
u_swpi_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);
